// File: design/utf8v_pkg.sv
// Shared types, codes and constants for the UTF-8 stream validator.
package utf8v_pkg;

  // Widths of the byte stream and result fields
  localparam int OFFSET_WIDTH_DEF = 16;
  localparam int OFF_OUT_W        = 16;
  localparam int CP_W             = 21;
  localparam int IN_TDATA_W       = 8;
  localparam int OUT_TDATA_W      = 40;
  localparam int OUT_TUSER_W      = 2;

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_LW    = 3;

  // Code point limits
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] LIM_1B     = 21'h000080;
  localparam logic [CP_W-1:0] LIM_2B     = 21'h000800;
  localparam logic [CP_W-1:0] LIM_3B     = 21'h010000;
  localparam logic [CP_W-1:0] BOM_CP     = 21'h00FEFF;

  typedef enum logic [1:0] {
    KIND_CP      = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_SUMMARY = 2'd2
  } utf8v_kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC      = 3'd1,
    ST_BADLEAD    = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_OVERLONG   = 3'd4,
    ST_BADCP      = 3'd5,
    ST_BOM        = 3'd6
  } utf8v_status_t;

  // One result beat
  typedef struct packed {
    utf8v_kind_t            kind;
    logic [CP_W-1:0]        cp_value;
    utf8v_status_t          status;
    logic [OFF_OUT_W-1:0]   offset;
    logic                   is_last;
  } utf8v_res_t;

  // Results raised by one input byte
  typedef struct packed {
    logic       r0_valid;
    utf8v_res_t r0;
    logic       r1_valid;
    utf8v_res_t r1;
  } utf8v_res_pair_t;

endpackage

// File: design/utf8v_decode.sv
// Per-byte decode: next state and up to two result beats for one byte.
module utf8v_decode
  import utf8v_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  input  logic                    reject_bom,
  input  logic [OFFSET_WIDTH-1:0] byte_count,
  input  logic [OFFSET_WIDTH-1:0] seq_start,
  input  logic [CP_W-1:0]         partial_value,
  input  logic [1:0]              bytes_left,
  input  logic [2:0]              seq_length,
  input  logic                    failed,
  input  utf8v_status_t           first_status,
  input  logic [OFFSET_WIDTH-1:0] first_offset,
  output logic [OFFSET_WIDTH-1:0] byte_count_next,
  output logic [OFFSET_WIDTH-1:0] seq_start_next,
  output logic [CP_W-1:0]         partial_value_next,
  output logic [1:0]              bytes_left_next,
  output logic [2:0]              seq_length_next,
  output logic                    failed_next,
  output utf8v_status_t           first_status_next,
  output logic [OFFSET_WIDTH-1:0] first_offset_next,
  output utf8v_res_pair_t         res
);

  localparam int EXT_W = (OFFSET_WIDTH > OFF_OUT_W) ? OFFSET_WIDTH : OFF_OUT_W;
  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

  // Low bits of an offset as carried on the result
  function automatic logic [OFF_OUT_W-1:0] out_off(input logic [OFFSET_WIDTH-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[OFF_OUT_W-1:0];
  endfunction

  // Range, surrogate, overlong and BOM checks on a finished sequence
  function automatic utf8v_status_t check_seq(input logic [CP_W-1:0] cp,
                                              input logic [2:0] len,
                                              input logic at_start,
                                              input logic rej);
    logic overlong;
    if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
      return ST_BADCP;
    end
    if (cp < LIM_1B) begin
      overlong = (len != 3'd1);
    end else if (cp < LIM_2B) begin
      overlong = (len != 3'd2);
    end else if (cp < LIM_3B) begin
      overlong = (len != 3'd3);
    end else begin
      overlong = 1'b0;
    end
    if (overlong) begin
      return ST_OVERLONG;
    end
    if (rej && at_start && len == 3'd3 && cp == BOM_CP) begin
      return ST_BOM;
    end
    return ST_OK;
  endfunction

  always_comb begin
    logic          do_finish;
    logic          do_fail;
    utf8v_status_t fail_st;
    utf8v_status_t chk;

    do_finish = 1'b0;
    do_fail   = 1'b0;
    fail_st   = ST_OK;
    chk       = ST_OK;

    byte_count_next    = (byte_count != OFF_MAX) ? byte_count + 1'b1 : byte_count;
    seq_start_next     = seq_start;
    partial_value_next = partial_value;
    bytes_left_next    = bytes_left;
    seq_length_next    = seq_length;
    failed_next        = failed;
    first_status_next  = first_status;
    first_offset_next  = first_offset;
    res                = '0;

    // Lead or continuation byte
    if (!failed) begin
      if (bytes_left == 2'd0) begin
        seq_start_next = byte_count;
        if (!data_byte[7]) begin
          seq_length_next    = 3'd1;
          partial_value_next = CP_W'(data_byte);
          do_finish          = 1'b1;
        end else if (data_byte[7:5] == 3'b110) begin
          seq_length_next    = 3'd2;
          partial_value_next = CP_W'(data_byte[4:0]);
          bytes_left_next    = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          seq_length_next    = 3'd3;
          partial_value_next = CP_W'(data_byte[3:0]);
          bytes_left_next    = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          seq_length_next    = 3'd4;
          partial_value_next = CP_W'(data_byte[2:0]);
          bytes_left_next    = 2'd3;
        end else begin
          seq_length_next = 3'd0;
          do_fail         = 1'b1;
          fail_st         = ST_BADLEAD;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        do_fail = 1'b1;
        fail_st = ST_INCOMPLETE;
      end else begin
        partial_value_next = {partial_value[CP_W-7:0], data_byte[5:0]};
        bytes_left_next    = bytes_left - 2'd1;
        do_finish          = (bytes_left == 2'd1);
      end
    end

    // Finished sequence: emit code point or error
    if (do_finish) begin
      chk = check_seq(partial_value_next, seq_length_next,
                      (seq_start_next == '0), reject_bom);
      if (chk == ST_OK) begin
        res.r0_valid        = 1'b1;
        res.r0.kind         = KIND_CP;
        res.r0.cp_value     = partial_value_next;
        res.r0.status       = ST_OK;
        res.r0.offset       = out_off(seq_start_next);
        res.r0.is_last      = 1'b0;
      end else begin
        do_fail = 1'b1;
        fail_st = chk;
      end
    end

    // String ends inside a sequence
    if (last_byte && !failed && !do_fail && bytes_left_next != 2'd0) begin
      do_fail = 1'b1;
      fail_st = ST_TRUNC;
    end

    if (do_fail) begin
      failed_next       = 1'b1;
      first_status_next = fail_st;
      first_offset_next = seq_start_next;
      bytes_left_next   = 2'd0;
      res.r0_valid      = 1'b1;
      res.r0.kind       = KIND_ERROR;
      res.r0.cp_value   = '0;
      res.r0.status     = fail_st;
      res.r0.offset     = out_off(seq_start_next);
      res.r0.is_last    = 1'b0;
    end

    // Summary on the closing byte, then clear for the next string
    if (last_byte) begin
      res.r1_valid      = 1'b1;
      res.r1.kind       = KIND_SUMMARY;
      res.r1.cp_value   = '0;
      res.r1.is_last    = 1'b1;
      if (failed_next) begin
        res.r1.status = first_status_next;
        res.r1.offset = out_off(first_offset_next);
      end else begin
        res.r1.status = ST_OK;
        res.r1.offset = out_off(byte_count_next);
      end
      byte_count_next    = '0;
      seq_start_next     = '0;
      partial_value_next = '0;
      bytes_left_next    = 2'd0;
      seq_length_next    = 3'd0;
      failed_next        = 1'b0;
      first_status_next  = ST_OK;
      first_offset_next  = '0;
    end
  end

endmodule

// File: design/utf8v_queue.sv
// Result queue: takes up to two beats a cycle, gives out one.
module utf8v_queue
  import utf8v_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push0,
  input  utf8v_res_t      din0,
  input  logic            push1,
  input  utf8v_res_t      din1,
  input  logic            pop,
  output utf8v_res_t      dout,
  output logic            not_empty,
  output logic [Q_LW-1:0] level
);

  utf8v_res_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW-1:0] wr_ptr_next;
  logic [Q_LW-1:0] level_next;

  // Pointer and fill level update
  always_comb begin
    wr_ptr_next = wr_ptr + Q_AW'(push0) + Q_AW'(push1);
    level_next  = level + Q_LW'(push0) + Q_LW'(push1) - Q_LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Storage; second beat lands behind the first
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= din0;
    end
    if (push1) begin
      mem[wr_ptr + 1'b1] <= din1;
    end
  end

  assign dout      = mem[rd_ptr];
  assign not_empty = (level != '0);

endmodule

// File: design/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator: state registers, decode and result queue.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------------
//  s_t*     | in        | tdata[7:0] data_byte; tlast last_byte
//  m_t*     | out       | tdata cp_value/status/offset; tuser kind; tlast is_last
//  cfg_*    | in        | cfg_wdata reject_bom, written when cfg_we is high
//
// One input byte per cycle; its decode is combinational from the state registers
// into a four-beat result queue. A closing byte raises up to two result beats, and the
// queue drains one beat a cycle, so s_tready drops while more than two beats wait.
// rst (synchronous) clears the string state and queue and sets reject_bom.
// An output stall never blocks input while the queue has room for two beats.
module utf8_stream_validator
  import utf8v_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,   // last_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [20:0] cp_value, [23:21] status,
                                            // [39:24] offset
  output logic [OUT_TUSER_W-1:0] m_tuser,   // [1:0] kind
  output logic                   m_tlast,   // is_last
  input  logic                   cfg_we,
  input  logic                   cfg_wdata  // reject_bom
);

  logic                    reject_bom;
  logic [OFFSET_WIDTH-1:0] byte_count;
  logic [OFFSET_WIDTH-1:0] seq_start;
  logic [CP_W-1:0]         partial_value;
  logic [1:0]              bytes_left;
  logic [2:0]              seq_length;
  logic                    failed;
  utf8v_status_t           first_status;
  logic [OFFSET_WIDTH-1:0] first_offset;

  logic [OFFSET_WIDTH-1:0] byte_count_next;
  logic [OFFSET_WIDTH-1:0] seq_start_next;
  logic [CP_W-1:0]         partial_value_next;
  logic [1:0]              bytes_left_next;
  logic [2:0]              seq_length_next;
  logic                    failed_next;
  utf8v_status_t           first_status_next;
  logic [OFFSET_WIDTH-1:0] first_offset_next;

  utf8v_res_pair_t  res;
  utf8v_res_t       q_din0;
  utf8v_res_t       q_dout;
  logic             q_push0;
  logic             q_push1;
  logic [Q_LW-1:0]  q_level;
  logic             in_beat;
  logic             out_beat;

  assign s_tready = (q_level <= Q_LW'(Q_DEPTH - 2));
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  // Per-byte decode
  utf8v_decode #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_decode (
    .data_byte          (s_tdata),
    .last_byte          (s_tlast),
    .reject_bom         (reject_bom),
    .byte_count         (byte_count),
    .seq_start          (seq_start),
    .partial_value      (partial_value),
    .bytes_left         (bytes_left),
    .seq_length         (seq_length),
    .failed             (failed),
    .first_status       (first_status),
    .first_offset       (first_offset),
    .byte_count_next    (byte_count_next),
    .seq_start_next     (seq_start_next),
    .partial_value_next (partial_value_next),
    .bytes_left_next    (bytes_left_next),
    .seq_length_next    (seq_length_next),
    .failed_next        (failed_next),
    .first_status_next  (first_status_next),
    .first_offset_next  (first_offset_next),
    .res                (res)
  );

  // String state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      reject_bom    <= 1'b1;
      byte_count    <= '0;
      seq_start     <= '0;
      partial_value <= '0;
      bytes_left    <= 2'd0;
      seq_length    <= 3'd0;
      failed        <= 1'b0;
      first_status  <= ST_OK;
      first_offset  <= '0;
    end else begin
      if (cfg_we) begin
        reject_bom <= cfg_wdata;
      end
      if (in_beat) begin
        byte_count    <= byte_count_next;
        seq_start     <= seq_start_next;
        partial_value <= partial_value_next;
        bytes_left    <= bytes_left_next;
        seq_length    <= seq_length_next;
        failed        <= failed_next;
        first_status  <= first_status_next;
        first_offset  <= first_offset_next;
      end
    end
  end

  // Pack results in order: a lone summary goes in the first slot
  assign q_push0 = in_beat && (res.r0_valid || res.r1_valid);
  assign q_push1 = in_beat && res.r0_valid && res.r1_valid;
  assign q_din0  = res.r0_valid ? res.r0 : res.r1;

  utf8v_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (q_push0),
    .din0      (q_din0),
    .push1     (q_push1),
    .din1      (res.r1),
    .pop       (out_beat),
    .dout      (q_dout),
    .not_empty (m_tvalid),
    .level     (q_level)
  );

  assign m_tdata = {q_dout.offset, 3'(q_dout.status), q_dout.cp_value};
  assign m_tuser = 2'(q_dout.kind);
  assign m_tlast = q_dout.is_last;

  // A closing byte leaves a cleared string state behind
  a_clear_after_last : assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tlast) |=> (byte_count == '0 && !failed && bytes_left == 2'd0))
    else $error("string state not cleared after closing byte");

  // The first error sticks until the string closes
  a_failed_sticky : assert property (@(posedge clk) disable iff (rst)
    (failed && !(in_beat && s_tlast)) |=> failed)
    else $error("error flag dropped inside a string");

  // Bytes after an error raise no result until the closing byte
  a_silent_after_error : assert property (@(posedge clk) disable iff (rst)
    (in_beat && failed && !s_tlast) |-> (!q_push0 && !q_push1))
    else $error("result raised after the first error");

  // Queue never overfills
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_level <= Q_LW'(Q_DEPTH))
    else $error("result queue overflow");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the UTF-8 stream validator: byte stream, decode model and checks.
`timescale 1ns / 1ps

module tb;
  import utf8v_pkg::*;

  localparam int          CYCLE_LIMIT = 100_000;
  localparam int          SETTLE      = 8;     // cycles allowed after the last result
  localparam int          HOLD_CYCLES = 300;   // long receiver stall
  localparam logic [1:0]  PREDICT     = 2'd3;  // row result count: take the model's results
  localparam utf8v_res_t  NO_BEAT     = '0;

  // One input beat, with optional typed-in results
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] n_typed;
    utf8v_res_t t0;
    utf8v_res_t t1;
  } stim_beat_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;
  logic                   cfg_we    = 1'b0;
  logic                   cfg_wdata = 1'b0;

  utf8_stream_validator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Bytes waiting to go out, the beat on the bus, and results still owed by the block
  stim_beat_t  byte_q [$];
  stim_beat_t  cur_beat = '0;
  utf8v_res_t  utf8_results_q [$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off      = 1'b0;
  logic pressure_go   = 1'b0;
  int   fail_count    = 0;
  int   res_seen      = 0;
  int   cycle_count   = 0;

  // Code point range per encoded length
  logic [20:0] cp_lo [4] = '{21'h0, 21'h80, 21'h800, 21'h10000};
  logic [20:0] cp_hi [4] = '{21'h7F, 21'h7FF, 21'hFFFF, 21'h10FFFF};

  // Decoder state, mirrored
  logic            bom_reject;
  logic [15:0]     next_off;
  logic [15:0]     seq_off;
  logic [20:0]     acc_cp;
  logic [1:0]      cont_left;
  logic [2:0]      seq_bytes;
  logic            str_bad;
  utf8v_status_t   bad_status;
  logic [15:0]     bad_off;

  function automatic utf8v_res_t make_beat(utf8v_kind_t k, logic [20:0] cp,
                                           utf8v_status_t st, logic [15:0] off, logic last);
    return {k, cp, st, off, last};
  endfunction

  function automatic utf8v_res_t err_beat(utf8v_status_t st, logic [15:0] off);
    return make_beat(KIND_ERROR, 21'h0, st, off, 1'b0);
  endfunction

  function automatic utf8v_res_t sum_beat(utf8v_status_t st, logic [15:0] off);
    return make_beat(KIND_SUMMARY, 21'h0, st, off, 1'b1);
  endfunction

  function automatic stim_beat_t plain_beat(logic [7:0] data, logic last);
    return {data, last, PREDICT, NO_BEAT, NO_BEAT};
  endfunction

  // Directed strings; typed results where they are obvious, model elsewhere
  stim_beat_t dir_tab [24] = '{
    // single byte extremes
    {8'h00, 1'b1, 2'd2, make_beat(KIND_CP, 21'h0, ST_OK, 16'd0, 1'b0), sum_beat(ST_OK, 16'd1)},
    {8'hFF, 1'b1, 2'd2, err_beat(ST_BADLEAD, 16'd0), sum_beat(ST_BADLEAD, 16'd0)},
    // stray continuation, then a byte that is ignored
    {8'h80, 1'b0, 2'd1, err_beat(ST_BADLEAD, 16'd0), NO_BEAT},
    {8'h41, 1'b1, 2'd1, sum_beat(ST_BADLEAD, 16'd0), NO_BEAT},
    // overlong NUL
    {8'hC0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'h80, 1'b1, 2'd2, err_beat(ST_OVERLONG, 16'd0), sum_beat(ST_OVERLONG, 16'd0)},
    // byte order mark with rejection on (reset value)
    {8'hEF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'hBB, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'hBF, 1'b1, 2'd2, err_beat(ST_BOM, 16'd0), sum_beat(ST_BOM, 16'd0)},
    // surrogate
    {8'hED, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'hA0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'h80, 1'b1, 2'd2, err_beat(ST_BADCP, 16'd0), sum_beat(ST_BADCP, 16'd0)},
    // above the last code point
    {8'hF4, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'h90, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'h80, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'h80, 1'b1, 2'd2, err_beat(ST_BADCP, 16'd0), sum_beat(ST_BADCP, 16'd0)},
    // missing continuation
    {8'hE2, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'h41, 1'b1, 2'd2, err_beat(ST_INCOMPLETE, 16'd0), sum_beat(ST_INCOMPLETE, 16'd0)},
    // string cut inside a sequence
    {8'hF0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    {8'h9F, 1'b1, 2'd2, err_beat(ST_TRUNC, 16'd0), sum_beat(ST_TRUNC, 16'd0)},
    // valid four byte sequence
    {8'hF0, 1'b0, PREDICT, NO_BEAT, NO_BEAT},
    {8'h9F, 1'b0, PREDICT, NO_BEAT, NO_BEAT},
    {8'h98, 1'b0, PREDICT, NO_BEAT, NO_BEAT},
    {8'h80, 1'b1, PREDICT, NO_BEAT, NO_BEAT}
  };

  // Packs a code point as len bytes, first byte in the low bits
  function automatic logic [31:0] utf8_encode(logic [20:0] cp, int len);
    logic [31:0] e;
    e = '0;
    case (len)
      1: e[7:0]  = {1'b0, cp[6:0]};
      2: e[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
      3: e[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: e = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    endcase
    return e;
  endfunction

  task automatic clear_string_state();
    next_off   = '0;
    seq_off    = '0;
    acc_cp     = '0;
    cont_left  = '0;
    seq_bytes  = '0;
    str_bad    = 1'b0;
    bad_status = ST_OK;
    bad_off    = '0;
  endtask

  // Checks a completed sequence: range, then overlong, then byte order mark
  function automatic utf8v_status_t seq_verdict();
    logic over;
    if (acc_cp > CP_MAX || (acc_cp >= SURR_LO && acc_cp <= SURR_HI))
      return ST_BADCP;
    if (acc_cp < LIM_1B)      over = (seq_bytes != 3'd1);
    else if (acc_cp < LIM_2B) over = (seq_bytes != 3'd2);
    else if (acc_cp < LIM_3B) over = (seq_bytes != 3'd3);
    else                      over = 1'b0;
    if (over)
      return ST_OVERLONG;
    if (bom_reject && seq_off == 16'd0 && seq_bytes == 3'd3 && acc_cp == BOM_CP)
      return ST_BOM;
    return ST_OK;
  endfunction

  // Decodes one byte and returns the result beats it raises
  task automatic utf8_decode_step(input logic [7:0] b, input logic last,
                                  output utf8v_res_t r [2], output int n);
    logic [15:0]   pos;
    logic          done;
    utf8v_status_t bad;
    pos  = next_off;
    n    = 0;
    done = 1'b0;
    bad  = ST_OK;
    r[0] = NO_BEAT;
    r[1] = NO_BEAT;
    if (next_off != 16'hFFFF)
      next_off = next_off + 16'd1;

    if (!str_bad) begin
      if (cont_left == 2'd0) begin
        seq_off = pos;
        if (!b[7]) begin
          seq_bytes = 3'd1; acc_cp = {14'd0, b[6:0]}; done = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          seq_bytes = 3'd2; acc_cp = {16'd0, b[4:0]}; cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          seq_bytes = 3'd3; acc_cp = {17'd0, b[3:0]}; cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          seq_bytes = 3'd4; acc_cp = {18'd0, b[2:0]}; cont_left = 2'd3;
        end else begin
          seq_bytes = 3'd0; bad = ST_BADLEAD;
        end
      end else if (b[7:6] != 2'b10) begin
        // the offending byte is not retried as a lead
        bad = ST_INCOMPLETE;
      end else begin
        acc_cp    = {acc_cp[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        done      = (cont_left == 2'd0);
      end
      if (done)
        bad = seq_verdict();
      if (bad == ST_OK && last && cont_left != 2'd0)
        bad = ST_TRUNC;
      if (bad != ST_OK) begin
        str_bad    = 1'b1;
        bad_status = bad;
        bad_off    = seq_off;
        cont_left  = 2'd0;
        r[n]       = err_beat(bad, seq_off);
        n++;
      end else if (done) begin
        r[n] = make_beat(KIND_CP, acc_cp, ST_OK, seq_off, 1'b0);
        n++;
      end
    end

    if (last) begin
      r[n] = str_bad ? sum_beat(bad_status, bad_off) : sum_beat(ST_OK, next_off);
      n++;
      clear_string_state();
    end
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH: %s", msg);
  endtask

  // Follows accepted bytes and register writes; checks each result beat in order
  always @(posedge clk) begin : scoreboard
    utf8v_res_t step_res [2];
    utf8v_res_t got;
    utf8v_res_t want;
    int         n_res;
    if (rst) begin
      bom_reject = 1'b1;
      clear_string_state();
      utf8_results_q.delete();
    end else begin
      if (cfg_we)
        bom_reject = cfg_wdata;
      if (s_tvalid && s_tready) begin
        utf8_decode_step(s_tdata, s_tlast, step_res, n_res);
        if (cur_beat.n_typed == PREDICT) begin
          for (int i = 0; i < n_res; i++)
            utf8_results_q.insert(utf8_results_q.size(), step_res[i]);
        end else begin
          if (cur_beat.n_typed >= 2'd1)
            utf8_results_q.insert(utf8_results_q.size(), cur_beat.t0);
          if (cur_beat.n_typed >= 2'd2)
            utf8_results_q.insert(utf8_results_q.size(), cur_beat.t1);
        end
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[20:0], m_tdata[23:21], m_tdata[39:24], m_tlast};
        if (utf8_results_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none pending", res_seen));
        end else begin
          want = utf8_results_q.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, wanted %0d",
                                      res_seen, got.kind, want.kind));
          if (got.cp_value !== want.cp_value)
            report_mismatch($sformatf("result %0d code point %h, wanted %h",
                                      res_seen, got.cp_value, want.cp_value));
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                      res_seen, got.status, want.status));
          if (got.offset !== want.offset)
            report_mismatch($sformatf("result %0d offset %0d, wanted %0d",
                                      res_seen, got.offset, want.offset));
          if (got.is_last !== want.is_last)
            report_mismatch($sformatf("result %0d last %0d, wanted %0d",
                                      res_seen, got.is_last, want.is_last));
        end
        res_seen++;
      end
    end
  end

  // Byte source: holds each beat until taken, idles at random between beats
  always @(posedge clk) begin : byte_source
    stim_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.data;
        s_tlast  <= nxt.last;
        cur_beat <= nxt;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus the long hold-off
  always @(posedge clk) begin : result_sink
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : long_hold
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic set_reject_bom(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Waits for every byte to go in and every result to come out, then settles
  task automatic wait_quiet();
    while (byte_q.size() != 0 || s_tvalid || utf8_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly well-formed strings with random content; some noise and broken sequences
  task automatic queue_random_strings(input int n_bytes);
    logic [7:0]  str [$];
    logic [7:0]  rb;
    logic [31:0] enc;
    logic [20:0] cp;
    int          queued, n_chars, roll, len, cut, k;
    bit          stop;
    queued = 0;
    while (queued < n_bytes) begin
      str.delete();
      if ($urandom_range(9) == 0) begin
        str.insert(str.size(), 8'hEF);
        str.insert(str.size(), 8'hBB);
        str.insert(str.size(), 8'hBF);
      end
      n_chars = $urandom_range(8, 1);
      stop    = 1'b0;
      for (int c = 0; c < n_chars && !stop; c++) begin
        roll = $urandom_range(99);
        cut  = 0;
        len  = $urandom_range(4, 1);
        cp   = 21'($urandom_range(cp_hi[len-1], cp_lo[len-1]));
        if (roll < 30) begin
          len = 1;
          cp  = 21'($urandom_range(8'h7F));
        end else if (roll >= 75 && roll < 80) begin
          // overlong: value fits in one byte fewer
          len = $urandom_range(4, 2);
          cp  = 21'($urandom_range(cp_hi[len-2], 0));
        end else if (roll >= 80 && roll < 84) begin
          len = 4;
          cp  = 21'($urandom_range(21'h1FFFFF, 21'h110000));
        end else if (roll >= 84 && roll < 96) begin
          len = $urandom_range(4, 2);
          cp  = 21'($urandom_range(cp_hi[len-1], cp_lo[len-1]));
        end else if (roll >= 96) begin
          len = 3;
          cp  = BOM_CP;
        end
        enc = utf8_encode(cp, len);
        if (roll >= 70 && roll < 75) begin
          // raw noise byte
          len      = 1;
          enc[7:0] = 8'($urandom_range(255));
        end else if (roll >= 84 && roll < 90) begin
          // drop the tail; often the string ends here
          cut  = $urandom_range(len - 1, 1);
          stop = 1'($urandom_range(1));
        end else if (roll >= 90 && roll < 96) begin
          // a continuation replaced by a byte that is not one
          k  = $urandom_range(len - 1, 1);
          rb = 8'($urandom_range(255));
          if (rb[7:6] == 2'b10)
            rb[6] = 1'b1;
          enc[8*k +: 8] = rb;
        end
        for (int j = 0; j < len - cut; j++)
          str.insert(str.size(), enc[8*j +: 8]);
      end
      foreach (str[j])
        byte_q.insert(byte_q.size(), plain_beat(str[j], j == str.size() - 1));
      queued += str.size();
    end
  endtask

  initial begin : run
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed strings, reset setting of the register
    send_idle_pct = 7;
    recv_idle_pct = 55;
    foreach (dir_tab[i])
      byte_q.insert(byte_q.size(), dir_tab[i]);
    wait_quiet();

    set_reject_bom(1'b0);
    queue_random_strings(505);
    wait_quiet();

    send_idle_pct = 55;
    recv_idle_pct = 7;
    set_reject_bom(1'b1);
    queue_random_strings(505);
    wait_quiet();

    // no idling; receiver holds off so the result queue fills
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_reject_bom(1'b0);
    queue_random_strings(505);
    pressure_go = 1'b1;
    wait_quiet();

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
